[hdl/icv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg: shared types and constants for the IPv4/TCP checksum verifier
// Byte offsets of the captured header fields, result status codes, the
// snapshot passed from the byte accumulator to the finish pipeline, and the
// ones-complement add used by the accumulator.
// ----------------------------------------------------------------------------
package icv_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_IP_BAD    = 2'd1,
    STATUS_TCP_BAD   = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_e;

  // Byte offsets inside the IPv4 header
  localparam logic [15:0] IdxVerIhl  = 16'd0;
  localparam logic [15:0] IdxTotalHi = 16'd2;
  localparam logic [15:0] IdxTotalLo = 16'd3;
  localparam logic [15:0] IdxProto   = 16'd9;
  localparam logic [15:0] IdxSrc0    = 16'd12;
  localparam logic [15:0] IdxSrc3    = 16'd15;
  localparam logic [15:0] IdxDst0    = 16'd16;
  localparam logic [15:0] IdxDst3    = 16'd19;

  // Byte counter saturates here
  localparam logic [15:0] IdxMax     = 16'hFFFF;

  // Packet state at the last byte, handed to the finish pipeline
  typedef struct packed {
    logic [15:0] last_idx;     // index of the last byte
    logic [5:0]  hdr_bytes;    // IHL * 4
    logic [15:0] total_len;    // IPv4 total length
    logic [15:0] ip_sum;       // folded header sum
    logic [15:0] tcp_sum;      // folded segment sum
    logic [31:0] src_addr;     // source address bytes seen so far
    logic [31:0] dst_addr;     // destination address bytes seen so far
    logic [7:0]  proto;        // protocol byte
    logic [7:0]  pend_byte;    // high byte of an unfinished word
  } snap_t;

  // Ones-complement add with end-around carry
  function automatic logic [15:0] add_fold(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hdl/icv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_if: valid/ready channels of the checksum verifier
// icv_byte_if carries packet bytes in, icv_result_if carries one verdict
// per packet out.
// ----------------------------------------------------------------------------
interface icv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icv_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] ip_result;
  logic [15:0] tcp_result;

  modport source (output valid, output status, output ip_result, output tcp_result,
                  input ready);
  modport sink   (input valid, input status, input ip_result, input tcp_result,
                  output ready);
endinterface

[hdl/icv_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_accum: per-byte header capture and checksum accumulation
// Registers each incoming byte, then folds it into the IP header sum or the
// TCP segment sum and captures the pseudo header fields. On the last byte of
// a packet the updated state is latched as a snapshot and the packet state
// is cleared.
// ----------------------------------------------------------------------------
module icv_accum import icv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  icv_byte_if.sink   pkt_i,
  output snap_t      snap_o,
  output logic       snap_valid_o,
  input  logic       snap_ready_i
);

  // Input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Packet state
  logic [15:0] idx_q, idx_d;
  logic [5:0]  hdr_q, hdr_d;
  logic [15:0] total_q, total_d;
  logic [15:0] ip_acc_q, ip_acc_d;
  logic [15:0] tcp_acc_q, tcp_acc_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  pend_q, pend_d;

  // Snapshot register
  logic  snap_v_q;
  snap_t snap_q;
  snap_t snap_d;

  logic        consume;
  logic        snap_take;
  logic        in_hdr;
  logic        in_seg;
  logic [15:0] word;

  // A last byte may only retire when the snapshot slot frees up
  assign snap_take = !snap_v_q || snap_ready_i;
  assign consume   = in_v_q && (!in_last_q || snap_take);
  assign pkt_i.ready = !in_v_q || consume;

  // Field capture at fixed offsets
  always_comb begin
    hdr_d   = hdr_q;
    total_d = total_q;
    if (idx_q == IdxVerIhl) begin
      hdr_d = {in_byte_q[3:0], 2'b00};
    end
    if (idx_q == IdxTotalHi) begin
      total_d = {in_byte_q, 8'h00};
    end
    if (idx_q == IdxTotalLo) begin
      total_d = {total_q[15:8], in_byte_q};
    end
  end

  // Header / segment sums over big-endian words
  assign in_hdr = idx_q < {10'd0, hdr_d};
  assign in_seg = !in_hdr && (idx_q < total_d);
  assign word   = {pend_q, in_byte_q};

  always_comb begin
    pend_d    = pend_q;
    ip_acc_d  = ip_acc_q;
    tcp_acc_d = tcp_acc_q;
    if ((in_hdr || in_seg) && !idx_q[0]) begin
      pend_d = in_byte_q;
    end
    if (in_hdr && idx_q[0]) begin
      ip_acc_d = add_fold(ip_acc_q, word);
    end
    if (in_seg && idx_q[0]) begin
      tcp_acc_d = add_fold(tcp_acc_q, word);
    end
  end

  // Pseudo header fields: protocol and both addresses, shifted in as they go by
  always_comb begin
    src_d   = src_q;
    dst_d   = dst_q;
    proto_d = proto_q;
    if (idx_q == IdxProto) begin
      proto_d = in_byte_q;
    end
    if (idx_q >= IdxSrc0 && idx_q <= IdxSrc3) begin
      src_d = {src_q[23:0], in_byte_q};
    end
    if (idx_q >= IdxDst0 && idx_q <= IdxDst3) begin
      dst_d = {dst_q[23:0], in_byte_q};
    end
  end

  // Saturating byte counter
  assign idx_d = (idx_q == IdxMax) ? idx_q : idx_q + 16'd1;

  // Snapshot of the state after the last byte
  always_comb begin
    snap_d.last_idx  = idx_q;
    snap_d.hdr_bytes = hdr_d;
    snap_d.total_len = total_d;
    snap_d.ip_sum    = ip_acc_d;
    snap_d.tcp_sum   = tcp_acc_d;
    snap_d.src_addr  = src_d;
    snap_d.dst_addr  = dst_d;
    snap_d.proto     = proto_d;
    snap_d.pend_byte = pend_d;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (pkt_i.ready) begin
      in_v_q <= pkt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      in_byte_q <= pkt_i.data_byte;
      in_last_q <= pkt_i.last_byte;
    end
  end

  // Packet state: advance per byte, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      hdr_q     <= '0;
      total_q   <= '0;
      ip_acc_q  <= '0;
      tcp_acc_q <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      proto_q   <= '0;
      pend_q    <= '0;
    end else if (consume) begin
      if (in_last_q) begin
        idx_q     <= '0;
        hdr_q     <= '0;
        total_q   <= '0;
        ip_acc_q  <= '0;
        tcp_acc_q <= '0;
        src_q     <= '0;
        dst_q     <= '0;
        proto_q   <= '0;
        pend_q    <= '0;
      end else begin
        idx_q     <= idx_d;
        hdr_q     <= hdr_d;
        total_q   <= total_d;
        ip_acc_q  <= ip_acc_d;
        tcp_acc_q <= tcp_acc_d;
        src_q     <= src_d;
        dst_q     <= dst_d;
        proto_q   <= proto_d;
        pend_q    <= pend_d;
      end
    end
  end

  // Snapshot slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (snap_take) begin
      snap_v_q <= consume && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take && consume && in_last_q) begin
      snap_q <= snap_d;
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_v_q;

endmodule

[hdl/icv_finish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_finish: end-of-packet checks and result register
// First stage checks the lengths and adds the pad, segment length and
// pseudo header into the TCP sum; second stage folds, complements, picks
// the status and holds the result until it is taken.
// ----------------------------------------------------------------------------
module icv_finish import icv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  snap_t        snap_i,
  input  logic         snap_valid_i,
  output logic         snap_ready_o,
  icv_result_if.source res_o
);

  // Stage B: checks and wide sum
  logic        sb_v_q;
  logic        hdr_zero_q, hdr_zero_d;
  logic        malformed_q, malformed_d;
  logic [15:0] ipr_q, ipr_d;
  logic [18:0] sum_q, sum_d;

  // Output register
  logic        out_v_q;
  status_e     status_q, status_d;
  logic [15:0] ip_res_q, ip_res_d;
  logic [15:0] tcp_res_q, tcp_res_d;

  logic        b_ready;
  logic [15:0] seg;
  logic [15:0] pad;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] tcpr;

  assign b_ready      = !out_v_q || res_o.ready;
  assign snap_ready_o = !sb_v_q || b_ready;

  // Length checks and TCP sum with pseudo header, segment length and odd-byte pad
  always_comb begin
    hdr_zero_d  = (snap_i.hdr_bytes == 6'd0);
    malformed_d = (snap_i.total_len < {10'd0, snap_i.hdr_bytes}) ||
                  (({1'b0, snap_i.last_idx} + 17'd1) < {1'b0, snap_i.total_len});
    ipr_d       = ~snap_i.ip_sum;
    seg         = snap_i.total_len - {10'd0, snap_i.hdr_bytes};
    pad         = seg[0] ? {snap_i.pend_byte, 8'h00} : 16'd0;
    sum_d       = {3'b000, snap_i.tcp_sum} + {3'b000, pad} + {3'b000, seg} +
                  {3'b000, snap_i.src_addr[31:16]} + {3'b000, snap_i.src_addr[15:0]} +
                  {3'b000, snap_i.dst_addr[31:16]} + {3'b000, snap_i.dst_addr[15:0]} +
                  {11'd0, snap_i.proto};
  end

  // Full carry fold, complement and verdict
  assign fold1 = {1'b0, sum_q[15:0]} + {14'd0, sum_q[18:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
  assign tcpr  = ~fold2;

  always_comb begin
    priority if (hdr_zero_q) begin
      status_d  = STATUS_IP_BAD;
      ip_res_d  = 16'hFFFF;
      tcp_res_d = 16'd0;
    end else if (malformed_q) begin
      status_d  = STATUS_MALFORMED;
      ip_res_d  = 16'd0;
      tcp_res_d = 16'd0;
    end else if (ipr_q != 16'd0) begin
      status_d  = STATUS_IP_BAD;
      ip_res_d  = ipr_q;
      tcp_res_d = 16'd0;
    end else begin
      status_d  = (tcpr != 16'd0) ? STATUS_TCP_BAD : STATUS_VALID;
      ip_res_d  = 16'd0;
      tcp_res_d = tcpr;
    end
  end

  // Stage B register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else if (snap_ready_o) begin
      sb_v_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      hdr_zero_q  <= hdr_zero_d;
      malformed_q <= malformed_d;
      ipr_q       <= ipr_d;
      sum_q       <= sum_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (b_ready) begin
      out_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && sb_v_q) begin
      status_q  <= status_d;
      ip_res_q  <= ip_res_d;
      tcp_res_q <= tcp_res_d;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.status     = status_q;
  assign res_o.ip_result  = ip_res_q;
  assign res_o.tcp_result = tcp_res_q;

endmodule

[hdl/ipv4_tcp_checksum_verify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_tcp_checksum_verify: IPv4 header and TCP checksum checker
// Sums an IPv4 packet byte stream into the header and TCP/pseudo header
// ones-complement sums and reports one verdict per packet.
//
//   channel  dir  handshake     payload
//   pkt_i    in   valid/ready   data_byte[7:0], last_byte
//   res_o    out  valid/ready   status[1:0], ip_result[15:0], tcp_result[15:0]
//
// One byte per cycle, back to back, unless a last byte waits for the snapshot
// slot. One result per packet passes the snapshot, stage B and result registers.
// rst_ni clears all packet state; every packet also starts from clean state.
// A stalled result holds back only last bytes behind it; two more packets'
// verdicts can queue in the snapshot slot and stage B before input backs up.
// ----------------------------------------------------------------------------
module ipv4_tcp_checksum_verify import icv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  icv_byte_if.sink     pkt_i,
  icv_result_if.source res_o
);

  snap_t snap;
  logic  snap_valid;
  logic  snap_ready;

  // Per-byte accumulation
  icv_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_i        (pkt_i),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready)
  );

  // End-of-packet checks
  icv_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .res_o        (res_o)
  );

endmodule
